// File: rtl/srhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srhc_pkg: shared types and constants for the scheduled relay controller
// Word layouts, schedule slot layout, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package srhc_pkg;

  localparam int MAX_PERIODS = 8;
  localparam int IDX_W       = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int PCNT_W      = $clog2(MAX_PERIODS + 1);

  localparam int HOUR_W     = 12;
  localparam int POWER_W    = 16;
  localparam int TEMP_W     = 8;
  localparam int TIME_W     = 32;
  localparam int REP_W      = 15;
  localparam int NUMP_W     = 4;
  localparam int EIDX_W     = 3;
  localparam int KIND_W     = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int ALU_W      = TIME_W + 2;

  // item opcodes
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // period kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ON    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POWER = 2'd3;

  // result command codes
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ON     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OFF    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_VALID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_ENABLED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SECONDS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PERIODS    = 3'd4;

  // temperature thresholds
  localparam logic signed [TEMP_W-1:0] TEMP_ABSENT  = -8'sd100;
  localparam logic signed [TEMP_W-1:0] LIMIT_UNUSED = 8'sd100;

  typedef struct packed {
    logic                       cmd;
    logic [HOUR_W-1:0]          hour;
    logic signed [POWER_W-1:0]  power;
    logic signed [TEMP_W-1:0]   temperature;
    logic [TIME_W-1:0]          now_seconds;
    logic [EIDX_W-1:0]          entry_index;
    logic [KIND_W-1:0]          entry_type;
    logic [HOUR_W-1:0]          entry_end_hour;
    logic signed [POWER_W-1:0]  entry_min_power;
    logic signed [POWER_W-1:0]  entry_max_power;
    logic signed [TEMP_W-1:0]   entry_temp_low;
    logic signed [TEMP_W-1:0]   entry_temp_high;
  } in_word_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             relay_is_on;
    logic             last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [HOUR_W-1:0]          start_hour;
    logic [HOUR_W-1:0]          end_hour;
    logic signed [POWER_W-1:0]  min_power;
    logic signed [POWER_W-1:0]  max_power;
    logic signed [TEMP_W-1:0]   temp_low;
    logic signed [TEMP_W-1:0]   temp_high;
  } period_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             lt;
  } alu_rsp_t;

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_WRITE     = 13'b0000000000010,
    ST_DISABLE   = 13'b0000000000100,
    ST_STATUS    = 13'b0000000001000,
    ST_RANGE_LO  = 13'b0000000010000,
    ST_RANGE_HI  = 13'b0000000100000,
    ST_FORCE     = 13'b0000001000000,
    ST_TEMP_LO   = 13'b0000010000000,
    ST_TEMP_HI   = 13'b0000100000000,
    ST_POWER_MIN = 13'b0001000000000,
    ST_POWER_MAX = 13'b0010000000000,
    ST_ELAPSED   = 13'b0100000000000,
    ST_REPEAT    = 13'b1000000000000
  } state_t;

endpackage
`default_nettype wire

// File: rtl/scheduled_relay_hysteresis_control.sv
`timescale 1ns / 1ps
`default_nettype none
// Write word: accepted in IDLE, stored to its slot in WRITE; no result word.
// Evaluate word: the sequencer steps each period in use through one shared compare
// unit; a period is skipped, forced or run through the power and temperature checks,
// and output stalls hold the sequencer in place.
// Sync active-low reset clears relay, command time, slots and configuration, but sets local mode.
// ----------------------------------------------------------------------------
// scheduled_relay_hysteresis_control: scheduled relay with power hysteresis
// Walks the schedule slots one compare at a time and emits relay commands
// and a final status word on each evaluation.
// ----------------------------------------------------------------------------
module scheduled_relay_hysteresis_control (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire srhc_pkg::in_word_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      srhc_pkg::out_word_t                 out_data,
  input  wire logic                                cfg_we,
  input  wire logic [srhc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [srhc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IDX_W  = srhc_pkg::IDX_W;
  localparam int PCNT_W = srhc_pkg::PCNT_W;
  localparam int ALU_W  = srhc_pkg::ALU_W;

  // configuration
  logic                          act_valid_r;
  logic                          act_enabled_r;
  logic                          local_mode_r;
  logic [srhc_pkg::REP_W-1:0]    repeat_r;
  logic [srhc_pkg::NUMP_W-1:0]   num_periods_r;

  // sequencer and datapath state
  srhc_pkg::state_t              state_r, state_nxt;
  srhc_pkg::in_word_t            item_r;
  srhc_pkg::period_t             periods_r [srhc_pkg::MAX_PERIODS];
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic                          relay_r, relay_nxt;
  logic [srhc_pkg::TIME_W-1:0]   last_cmd_r;
  logic                          ok_r, ok_nxt;
  logic [srhc_pkg::TIME_W-1:0]   elapsed_r, elapsed_nxt;
  logic                          out_valid_r;
  srhc_pkg::out_word_t           out_r;

  // combinational helpers
  logic                          in_fire;
  logic                          slot_free;
  logic                          emit;
  logic [srhc_pkg::CMD_W-1:0]    emit_cmd;
  logic                          emit_last;
  logic [PCNT_W-1:0]             n_used;
  logic                          last_period;
  logic [IDX_W-1:0]              wr_idx;
  logic [IDX_W-1:0]              rd_idx;
  srhc_pkg::period_t             rd_entry;
  logic [srhc_pkg::HOUR_W-1:0]   prev_end;
  logic                          wr_in_range;
  logic                          temp_present;
  logic                          on_allowed;
  logic                          off_allowed;
  logic                          remote_repeat;
  srhc_pkg::alu_req_t            alu_req;
  srhc_pkg::alu_rsp_t            alu_rsp;

  assign in_ready  = (state_r == srhc_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // clamp the slot count to the storage depth
  assign n_used = (int'(num_periods_r) > srhc_pkg::MAX_PERIODS) ?
                  PCNT_W'(srhc_pkg::MAX_PERIODS) : PCNT_W'(num_periods_r);
  assign last_period = ((PCNT_W'(idx_r) + PCNT_W'(1)) == n_used);

  // one read port: previous slot during a write, current slot otherwise
  assign wr_idx      = IDX_W'(item_r.entry_index);
  assign wr_in_range = int'(item_r.entry_index) < srhc_pkg::MAX_PERIODS;
  assign rd_idx      = (state_r == srhc_pkg::ST_WRITE) ? (wr_idx - IDX_W'(1)) : idx_r;
  assign rd_entry    = periods_r[rd_idx];
  assign prev_end    = (wr_idx == '0) ? '0 : rd_entry.end_hour;

  assign temp_present  = $signed(item_r.temperature) > srhc_pkg::TEMP_ABSENT;
  // remote mode switches only on a change; on also needs a repeat interval
  assign on_allowed    = local_mode_r || (!relay_r && (repeat_r != '0));
  assign off_allowed   = local_mode_r || relay_r;
  assign remote_repeat = !local_mode_r && (repeat_r != '0);

  srhc_cmp_unit u_cmp (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // operand select for the shared compare unit
  always_comb begin
    alu_req = '0;
    unique case (state_r)
      srhc_pkg::ST_RANGE_LO: begin
        alu_req.a = ALU_W'(item_r.hour);
        alu_req.b = ALU_W'(rd_entry.start_hour);
      end
      srhc_pkg::ST_RANGE_HI: begin
        alu_req.a = ALU_W'(rd_entry.end_hour);
        alu_req.b = ALU_W'(item_r.hour);
      end
      srhc_pkg::ST_TEMP_LO: begin
        alu_req.a = {{(ALU_W-srhc_pkg::TEMP_W){rd_entry.temp_low[srhc_pkg::TEMP_W-1]}},
                     rd_entry.temp_low};
        alu_req.b = {{(ALU_W-srhc_pkg::TEMP_W){item_r.temperature[srhc_pkg::TEMP_W-1]}},
                     item_r.temperature};
      end
      srhc_pkg::ST_TEMP_HI: begin
        alu_req.a = {{(ALU_W-srhc_pkg::TEMP_W){item_r.temperature[srhc_pkg::TEMP_W-1]}},
                     item_r.temperature};
        alu_req.b = {{(ALU_W-srhc_pkg::TEMP_W){rd_entry.temp_high[srhc_pkg::TEMP_W-1]}},
                     rd_entry.temp_high};
      end
      srhc_pkg::ST_POWER_MIN: begin
        alu_req.a = {{(ALU_W-srhc_pkg::POWER_W){item_r.power[srhc_pkg::POWER_W-1]}},
                     item_r.power};
        alu_req.b = {{(ALU_W-srhc_pkg::POWER_W){rd_entry.min_power[srhc_pkg::POWER_W-1]}},
                     rd_entry.min_power};
      end
      srhc_pkg::ST_POWER_MAX: begin
        alu_req.a = {{(ALU_W-srhc_pkg::POWER_W){rd_entry.max_power[srhc_pkg::POWER_W-1]}},
                     rd_entry.max_power};
        alu_req.b = {{(ALU_W-srhc_pkg::POWER_W){item_r.power[srhc_pkg::POWER_W-1]}},
                     item_r.power};
      end
      srhc_pkg::ST_ELAPSED: begin
        alu_req.a = ALU_W'(item_r.now_seconds);
        alu_req.b = ALU_W'(last_cmd_r);
      end
      srhc_pkg::ST_REPEAT: begin
        alu_req.a = ALU_W'(repeat_r);
        alu_req.b = ALU_W'(elapsed_r);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // sequencer: one compare per cycle, hold in place while a word must go
  // out and the output register is still full
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    relay_nxt   = relay_r;
    ok_nxt      = ok_r;
    elapsed_nxt = elapsed_r;
    emit        = 1'b0;
    emit_cmd    = srhc_pkg::CMD_STATUS;
    emit_last   = 1'b0;
    unique case (state_r)
      srhc_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = '0;
          if (in_data.cmd == srhc_pkg::OP_WRITE) begin
            state_nxt = srhc_pkg::ST_WRITE;
          end else if (!act_valid_r || (act_enabled_r && (n_used == '0))) begin
            state_nxt = srhc_pkg::ST_STATUS;
          end else if (!act_enabled_r) begin
            state_nxt = srhc_pkg::ST_DISABLE;
          end else begin
            state_nxt = srhc_pkg::ST_RANGE_LO;
          end
        end
      end
      srhc_pkg::ST_WRITE: begin
        state_nxt = srhc_pkg::ST_IDLE;
      end
      srhc_pkg::ST_DISABLE: begin
        // force the relay off; announce it unless remote and already off
        if (off_allowed) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_cmd  = srhc_pkg::CMD_OFF;
            relay_nxt = 1'b0;
            state_nxt = srhc_pkg::ST_STATUS;
          end
        end else begin
          relay_nxt = 1'b0;
          state_nxt = srhc_pkg::ST_STATUS;
        end
      end
      srhc_pkg::ST_STATUS: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_cmd  = srhc_pkg::CMD_STATUS;
          emit_last = 1'b1;
          state_nxt = srhc_pkg::ST_IDLE;
        end
      end
      srhc_pkg::ST_RANGE_LO: begin
        // hour below the slot start: skip the slot
        if (alu_rsp.lt) begin
          if (last_period) begin
            state_nxt = srhc_pkg::ST_STATUS;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = srhc_pkg::ST_RANGE_LO;
          end
        end else begin
          state_nxt = srhc_pkg::ST_RANGE_HI;
        end
      end
      srhc_pkg::ST_RANGE_HI: begin
        if (!alu_rsp.lt && ((rd_entry.kind == srhc_pkg::KIND_OFF) ||
                            (rd_entry.kind == srhc_pkg::KIND_ON))) begin
          state_nxt = srhc_pkg::ST_FORCE;
        end else if (!alu_rsp.lt && (rd_entry.kind == srhc_pkg::KIND_POWER)) begin
          state_nxt = srhc_pkg::ST_TEMP_LO;
        end else if (last_period) begin
          state_nxt = srhc_pkg::ST_STATUS;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = srhc_pkg::ST_RANGE_LO;
        end
      end
      srhc_pkg::ST_FORCE: begin
        if ((rd_entry.kind == srhc_pkg::KIND_ON) ? on_allowed : off_allowed) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_cmd  = (rd_entry.kind == srhc_pkg::KIND_ON) ?
                        srhc_pkg::CMD_ON : srhc_pkg::CMD_OFF;
            relay_nxt = (rd_entry.kind == srhc_pkg::KIND_ON);
            if (last_period) begin
              state_nxt = srhc_pkg::ST_STATUS;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = srhc_pkg::ST_RANGE_LO;
            end
          end
        end else if (last_period) begin
          state_nxt = srhc_pkg::ST_STATUS;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = srhc_pkg::ST_RANGE_LO;
        end
      end
      srhc_pkg::ST_TEMP_LO: begin
        // too warm blocks switching on
        ok_nxt    = !(temp_present && ($signed(rd_entry.temp_low) <= srhc_pkg::LIMIT_UNUSED)
                      && alu_rsp.lt);
        state_nxt = srhc_pkg::ST_TEMP_HI;
      end
      srhc_pkg::ST_TEMP_HI: begin
        // too cold blocks switching on
        ok_nxt    = ok_r && !(temp_present &&
                    ($signed(rd_entry.temp_high) <= srhc_pkg::LIMIT_UNUSED) && alu_rsp.lt);
        state_nxt = srhc_pkg::ST_POWER_MIN;
      end
      srhc_pkg::ST_POWER_MIN: begin
        if (alu_rsp.lt && ok_r && on_allowed) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_cmd  = srhc_pkg::CMD_ON;
            relay_nxt = 1'b1;
            state_nxt = srhc_pkg::ST_POWER_MAX;
          end
        end else begin
          state_nxt = srhc_pkg::ST_POWER_MAX;
        end
      end
      srhc_pkg::ST_POWER_MAX: begin
        if ((alu_rsp.lt || !ok_r) && off_allowed && !slot_free) begin
          state_nxt = srhc_pkg::ST_POWER_MAX;
        end else begin
          if ((alu_rsp.lt || !ok_r) && off_allowed) begin
            emit      = 1'b1;
            emit_cmd  = srhc_pkg::CMD_OFF;
            relay_nxt = 1'b0;
          end
          if (remote_repeat) begin
            state_nxt = srhc_pkg::ST_ELAPSED;
          end else if (last_period) begin
            state_nxt = srhc_pkg::ST_STATUS;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = srhc_pkg::ST_RANGE_LO;
          end
        end
      end
      srhc_pkg::ST_ELAPSED: begin
        // seconds since the last command, modulo the counter width
        elapsed_nxt = alu_rsp.diff[srhc_pkg::TIME_W-1:0];
        state_nxt   = srhc_pkg::ST_REPEAT;
      end
      srhc_pkg::ST_REPEAT: begin
        // interval passed: resend the current relay state
        if (alu_rsp.lt && !slot_free) begin
          state_nxt = srhc_pkg::ST_REPEAT;
        end else begin
          if (alu_rsp.lt) begin
            emit     = 1'b1;
            emit_cmd = relay_r ? srhc_pkg::CMD_ON : srhc_pkg::CMD_OFF;
          end
          if (last_period) begin
            state_nxt = srhc_pkg::ST_STATUS;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = srhc_pkg::ST_RANGE_LO;
          end
        end
      end
      default: begin
        state_nxt = srhc_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r   <= 1'b0;
      act_enabled_r <= 1'b0;
      local_mode_r  <= 1'b1;
      repeat_r      <= '0;
      num_periods_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srhc_pkg::REG_ACTION_VALID:   act_valid_r   <= cfg_wdata[0];
        srhc_pkg::REG_ACTION_ENABLED: act_enabled_r <= cfg_wdata[0];
        srhc_pkg::REG_LOCAL_MODE:     local_mode_r  <= cfg_wdata[0];
        srhc_pkg::REG_REPEAT_SECONDS: repeat_r      <= cfg_wdata[srhc_pkg::REP_W-1:0];
        srhc_pkg::REG_NUM_PERIODS:    num_periods_r <= cfg_wdata[srhc_pkg::NUMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // schedule slots; the start of a slot is the end of the slot below it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < srhc_pkg::MAX_PERIODS; k++) begin
        periods_r[k] <= '0;
      end
    end else if ((state_r == srhc_pkg::ST_WRITE) && wr_in_range) begin
      periods_r[wr_idx].kind       <= item_r.entry_type;
      periods_r[wr_idx].start_hour <= prev_end;
      periods_r[wr_idx].end_hour   <= item_r.entry_end_hour;
      periods_r[wr_idx].min_power  <= item_r.entry_min_power;
      periods_r[wr_idx].max_power  <= item_r.entry_max_power;
      periods_r[wr_idx].temp_low   <= item_r.entry_temp_low;
      periods_r[wr_idx].temp_high  <= item_r.entry_temp_high;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srhc_pkg::ST_IDLE;
      idx_r       <= '0;
      relay_r     <= 1'b0;
      last_cmd_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      relay_r <= relay_nxt;
      // every relay command stamps its time
      if (emit && (emit_cmd != srhc_pkg::CMD_STATUS)) begin
        last_cmd_r <= item_r.now_seconds;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    ok_r      <= ok_nxt;
    elapsed_r <= elapsed_nxt;
    if (emit) begin
      out_r.command     <= emit_cmd;
      out_r.relay_is_on <= relay_nxt;
      out_r.last_of_run <= emit_last;
    end
  end

endmodule
`default_nettype wire

// File: rtl/srhc_cmp_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srhc_cmp_unit: shared subtract and compare unit
// Signed difference of two extended operands; the sign gives a < b.
// ----------------------------------------------------------------------------
module srhc_cmp_unit (
  input  srhc_pkg::alu_req_t req,
  output srhc_pkg::alu_rsp_t rsp
);

  logic [srhc_pkg::ALU_W-1:0] diff;

  assign diff     = req.a - req.b;
  assign rsp.diff = diff;
  assign rsp.lt   = diff[srhc_pkg::ALU_W-1];

endmodule
`default_nettype wire

// File: dv/scheduled_relay_hysteresis_control_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scheduled_relay_hysteresis_control_tb: self-checking bench for the relay
// Drives schedule writes and evaluations through the valid/ready input,
// predicts every relay command and status word in a scoreboard, and checks
// each word that leaves the block. Both sides idle at random, and the
// configuration is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module scheduled_relay_hysteresis_control_tb;
  import srhc_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RX_HOLD      = 400;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 42;
  localparam int HOLD_PHASE   = 2;
  localparam int FLOW_PHASE   = 5;
  localparam int MAX_HOUR     = 2400;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of the schedule, relay state and registers.
  // Each accepted input word is folded into that state and the words it
  // must produce are queued; each output word is checked against the queue.
  // --------------------------------------------------------------------------
  class relay_schedule_scoreboard;
    bit                 act_valid;
    bit                 act_enabled;
    bit                 local_drive;
    logic [REP_W-1:0]   repeat_s;
    logic [NUMP_W-1:0]  num_periods;
    bit                 relay;
    logic [TIME_W-1:0]  last_cmd;
    period_t            slots[MAX_PERIODS];
    out_word_t          relay_words_due[$];
    int                 errors;
    int                 writes;
    int                 evals;
    int                 words_checked;
    int                 on_words;
    int                 off_words;
    int                 status_words;

    function new();
      act_valid   = 1'b0;
      act_enabled = 1'b0;
      local_drive = 1'b1;
      repeat_s    = '0;
      num_periods = '0;
      relay       = 1'b0;
      last_cmd    = '0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ACTION_VALID:   act_valid   = data[0];
        REG_ACTION_ENABLED: act_enabled = data[0];
        REG_LOCAL_MODE:     local_drive = data[0];
        REG_REPEAT_SECONDS: repeat_s    = data[REP_W-1:0];
        REG_NUM_PERIODS:    num_periods = data[NUMP_W-1:0];
        default: ;
      endcase
    endfunction

    function void emit(logic [CMD_W-1:0] code, logic [TIME_W-1:0] now, bit last);
      out_word_t w;
      w.command     = code;
      w.relay_is_on = relay;
      w.last_of_run = last;
      relay_words_due.push_back(w);
      if (code != CMD_STATUS) last_cmd = now;
      if (code == CMD_ON) on_words++;
      else if (code == CMD_OFF) off_words++;
      else status_words++;
    endfunction

    function void drive(bit on, logic [TIME_W-1:0] now);
      relay = on;
      emit(on ? CMD_ON : CMD_OFF, now, 1'b0);
    endfunction

    function void apply_input_word(in_word_t w);
      int                unsigned n;
      int                i;
      int                pw;
      int                tc;
      int                tlo;
      int                thi;
      bit                ok;
      bit                was;
      logic [TIME_W-1:0] elapsed;
      if (w.cmd == OP_WRITE) begin
        // entry_index is 3 bits wide, so every slot exists with eight periods
        writes++;
        i = w.entry_index;
        slots[i].kind       = w.entry_type;
        slots[i].end_hour   = w.entry_end_hour;
        slots[i].start_hour = (i == 0) ? '0 : slots[i-1].end_hour;
        slots[i].min_power  = w.entry_min_power;
        slots[i].max_power  = w.entry_max_power;
        slots[i].temp_low   = w.entry_temp_low;
        slots[i].temp_high  = w.entry_temp_high;
        return;
      end
      evals++;
      if (act_valid) begin
        if (act_enabled) begin
          n = (num_periods > MAX_PERIODS) ? MAX_PERIODS : num_periods;
          for (i = 0; i < int'(n); i++) begin
            if (w.hour < slots[i].start_hour || w.hour > slots[i].end_hour) continue;
            case (slots[i].kind)
              KIND_OFF: begin
                if (local_drive || relay) drive(1'b0, w.now_seconds);
              end
              KIND_ON: begin
                if (local_drive || (!relay && repeat_s != 0)) drive(1'b1, w.now_seconds);
              end
              KIND_POWER: begin
                pw  = $signed(w.power);
                tc  = $signed(w.temperature);
                tlo = $signed(slots[i].temp_low);
                thi = $signed(slots[i].temp_high);
                ok  = 1'b1;
                if (tc > -100) begin
                  if (tlo <= 100 && tc > tlo) ok = 1'b0;
                  if (thi <= 100 && tc < thi) ok = 1'b0;
                end
                if (pw < $signed(slots[i].min_power) && ok) begin
                  if (local_drive || (!relay && repeat_s != 0)) drive(1'b1, w.now_seconds);
                end
                if (pw > $signed(slots[i].max_power) || !ok) begin
                  if (local_drive || relay) drive(1'b0, w.now_seconds);
                end
                elapsed = w.now_seconds - last_cmd;
                if (!local_drive && repeat_s != 0 && elapsed > repeat_s)
                  drive(relay, w.now_seconds);
              end
              default: ;
            endcase
          end
        end else begin
          was   = relay;
          relay = 1'b0;
          if (local_drive || was) emit(CMD_OFF, w.now_seconds, 1'b0);
        end
      end
      emit(CMD_STATUS, w.now_seconds, 1'b1);
    endfunction

    function void check_relay_word(out_word_t got);
      out_word_t want;
      words_checked++;
      if (relay_words_due.size() == 0) begin
        $error("unexpected result word: command %0d relay_is_on %0d last_of_run %0d",
               got.command, got.relay_is_on, got.last_of_run);
        errors++;
        return;
      end
      want = relay_words_due.pop_front();
      if (got.command !== want.command) begin
        $error("command: expected %0d, actual %0d", want.command, got.command);
        errors++;
      end
      if (got.relay_is_on !== want.relay_is_on) begin
        $error("relay_is_on: expected %0d, actual %0d", want.relay_is_on, got.relay_is_on);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  in_word_t                in_data;
  logic                    out_valid;
  logic                    out_ready;
  out_word_t               out_data;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  relay_schedule_scoreboard sb;
  int                       cycle_count;
  int                       config_phases;
  bit                       hold_req;
  bit                       free_flow;
  logic [TIME_W-1:0]        now_s;

  scheduled_relay_hysteresis_control u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Hard stop: a hung handshake or a missing result word ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check every word the block hands over. Signals are read in the active
  // region right after the edge, so they still hold their pre-edge values.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_relay_word(out_data);
  end

  // Idle length shared by both sides: mostly short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: bursts of ready and random stalls. A hold request drops ready
  // for a long stretch so that the block backs up into its input.
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (free_flow || $urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  // Fill every field with random bits so each bit of the word toggles;
  // callers overwrite what matters for the operation.
  function automatic in_word_t noise_word();
    in_word_t w;
    w.cmd             = 1'($urandom);
    w.hour            = 12'($urandom_range(0, MAX_HOUR));
    w.power           = 16'($urandom);
    w.temperature     = 8'($urandom);
    w.now_seconds     = $urandom;
    w.entry_index     = 3'($urandom);
    w.entry_type      = 2'($urandom);
    w.entry_end_hour  = 12'($urandom_range(0, MAX_HOUR));
    w.entry_min_power = 16'($urandom);
    w.entry_max_power = 16'($urandom);
    w.entry_temp_low  = 8'($urandom);
    w.entry_temp_high = 8'($urandom);
    return w;
  endfunction

  function automatic in_word_t eval_word(int hr, int pw, int tc, logic [TIME_W-1:0] now);
    in_word_t w;
    w             = noise_word();
    w.cmd         = OP_EVAL;
    w.hour        = 12'(hr);
    w.power       = 16'(pw);
    w.temperature = 8'(tc);
    w.now_seconds = now;
    return w;
  endfunction

  function automatic in_word_t slot_word(int idx, logic [KIND_W-1:0] kind, int end_hr,
                                         int minp, int maxp, int tlo, int thi);
    in_word_t w;
    w                 = noise_word();
    w.cmd             = OP_WRITE;
    w.entry_index     = 3'(idx);
    w.entry_type      = kind;
    w.entry_end_hour  = 12'(end_hr);
    w.entry_min_power = 16'(minp);
    w.entry_max_power = 16'(maxp);
    w.entry_temp_low  = 8'(tlo);
    w.entry_temp_high = 8'(thi);
    return w;
  endfunction

  // Offer one word and hold it until accepted; note it at the accepting edge.
  // Valid either stays high on return, so a back-to-back word needs no second write, or drops for a random idle first.
  task automatic send_word(input in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_input_word(w);
    if (!free_flow && $urandom_range(0, 1) == 1) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Stop offering, wait for every predicted word, then give a trailing write
  // time to finish before the registers may change.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.relay_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    sb.set_reg(idx, CFG_DATA_W'(data));
    @(posedge clk);
  endtask

  // Write all five registers back to back, lowering the enable once.
  task automatic set_config(input int valid, input int en, input int lm,
                            input int rp, input int np);
    put_reg(REG_ACTION_VALID, valid);
    put_reg(REG_ACTION_ENABLED, en);
    put_reg(REG_LOCAL_MODE, lm);
    put_reg(REG_REPEAT_SECONDS, rp);
    put_reg(REG_NUM_PERIODS, np);
    cfg_we <= 1'b0;
    config_phases++;
  endtask

  // Directed part: boundaries of the schedule, field extremes, the absent
  // temperature, unused limits, remote repeat with wrap, disabled action.
  task automatic run_directed();
    // action not valid: status word only
    send_word(eval_word(1200, 0, 25, 32'd10));
    send_word(slot_word(0, KIND_ON, 600, 0, 0, 0, 0));
    send_word(slot_word(1, KIND_OFF, 1200, 0, 0, 0, 0));
    // power slot with both limits unused
    send_word(slot_word(2, KIND_POWER, 1800, 0, 1000, 101, 127));
    // extreme thresholds, low limit at the last active value
    send_word(slot_word(3, KIND_POWER, MAX_HOUR, 32767, -32768, 100, -128));
    send_word(slot_word(4, KIND_POWER, MAX_HOUR, -32768, 32767, 20, 10));
    send_word(slot_word(5, KIND_NONE, MAX_HOUR, 0, 0, 0, 0));
    send_word(slot_word(6, KIND_ON, MAX_HOUR, 0, 0, 0, 0));
    // starts at 2400 and ends at 0: never matches
    send_word(slot_word(7, KIND_OFF, 0, 0, 0, 0, 0));
    settle();
    // period count above the slot count is clipped
    set_config(1, 1, 1, 0, 15);
    send_word(eval_word(0, 0, 25, 32'd20));
    send_word(eval_word(600, 0, 25, 32'd21));
    send_word(eval_word(1800, -32768, -128, 32'd22));
    send_word(eval_word(MAX_HOUR, 32767, 127, 32'd23));
    send_word(eval_word(2100, 0, -100, 32'd24));
    send_word(eval_word(2100, 0, -99, 32'd25));
    settle();
    // remote without repeat: switching on is impossible
    set_config(1, 1, 0, 0, MAX_PERIODS);
    send_word(eval_word(1500, -50, 15, 32'd900));
    settle();
    set_config(1, 1, 0, 1, 3);
    send_word(eval_word(1500, -50, 15, 32'd1000));
    send_word(eval_word(1500, 500, 15, 32'd1001));
    send_word(eval_word(1500, 500, 15, 32'd1005));
    send_word(eval_word(1500, 2000, 15, 32'hFFFF_FFFF));
    settle();
    set_config(1, 0, 0, 32000, 3);
    send_word(eval_word(1500, 0, 0, 32'd2000));
    send_word(eval_word(1500, 0, 0, 32'd2001));
    settle();
    set_config(1, 0, 1, 32000, 3);
    send_word(eval_word(1500, 0, 0, 32'd2002));
    settle();
    set_config(1, 1, 1, 0, 0);
    send_word(eval_word(1500, 0, 0, 32'd2003));
  endtask

  // One random phase: fresh registers, an in-order schedule, then mostly
  // evaluations with a few stray slot writes mixed in.
  task automatic run_phase(input int ph);
    int n_slots;
    int k;
    int prev;
    int end_hr;
    int minp;
    int maxp;
    int tlo;
    int thi;
    int r;
    int rp;
    int np;
    int hr;
    int pw;
    int tc;
    logic [KIND_W-1:0] kind;
    settle();
    n_slots = $urandom_range(1, MAX_PERIODS);
    r  = $urandom_range(0, 99);
    rp = (r < 15) ? 0 : (r < 25) ? 32000 : $urandom_range(1, 12);
    np = ($urandom_range(0, 9) < 7) ? n_slots : $urandom_range(0, 15);
    set_config((ph == 3) ? 0 : 1, (ph == 6) ? 0 : int'($urandom_range(0, 9) != 0),
               ph % 2, rp, np);
    free_flow = (ph == FLOW_PHASE);
    prev = 0;
    for (k = 0; k < n_slots; k++) begin
      end_hr = (k == n_slots - 1 && $urandom_range(0, 1) == 1) ? MAX_HOUR :
               prev + $urandom_range(0, MAX_HOUR / n_slots + 100);
      if (end_hr > MAX_HOUR) end_hr = MAX_HOUR;
      prev = end_hr;
      kind = ($urandom_range(0, 1) == 1) ? KIND_POWER : KIND_W'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 15) begin
        minp = $signed(16'($urandom));
        maxp = $signed(16'($urandom));
      end else begin
        minp = $urandom_range(0, 1200) - 800;
        maxp = minp + $urandom_range(0, 900);
      end
      r   = $urandom_range(0, 99);
      tlo = (r < 10) ? $signed(8'($urandom)) : (r < 40) ? $urandom_range(101, 127) :
            $urandom_range(10, 90);
      r   = $urandom_range(0, 99);
      thi = (r < 10) ? $signed(8'($urandom)) : (r < 40) ? $urandom_range(101, 127) :
            $urandom_range(0, 70) - 40;
      send_word(slot_word(k, kind, end_hr, minp, maxp, tlo, thi));
    end
    // let the result side back up while the input keeps offering
    if (ph == HOLD_PHASE) hold_req = 1'b1;
    for (k = n_slots; k < PHASE_WORDS; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        // stray write: any slot, any content, breaks the schedule order
        send_word(slot_word($urandom_range(0, MAX_PERIODS - 1), KIND_W'($urandom),
                            $urandom_range(0, MAX_HOUR), $signed(16'($urandom)),
                            $signed(16'($urandom)), $signed(8'($urandom)),
                            $signed(8'($urandom))));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) now_s = $urandom;
        else if (r < 10) now_s = now_s + $urandom_range(0, 65535);
        else now_s = now_s + $urandom_range(0, 4);
        if ($urandom_range(0, 99) < 40) begin
          // land on or next to a period boundary
          hr = sb.slots[$urandom_range(0, MAX_PERIODS - 1)].end_hour;
          hr = hr + $urandom_range(0, 2) - 1;
          if (hr < 0) hr = 0;
          if (hr > MAX_HOUR) hr = MAX_HOUR;
        end else begin
          hr = $urandom_range(0, MAX_HOUR);
        end
        pw = ($urandom_range(0, 99) < 25) ? $signed(16'($urandom)) :
             $urandom_range(0, 2400) - 1200;
        tc = ($urandom_range(0, 99) < 20) ? $signed(8'($urandom)) :
             $urandom_range(0, 140) - 30;
        send_word(eval_word(hr, pw, tc, now_s));
      end
    end
    free_flow = 1'b0;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    cycle_count   = 0;
    config_phases = 0;
    hold_req      = 1'b0;
    free_flow     = 1'b0;
    now_s         = 32'd5000;
    sb            = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    for (int ph = 0; ph < NUM_PHASES; ph++) run_phase(ph);

    // drain: everything predicted must arrive, then nothing more may follow
    settle();
    if (sb.relay_words_due.size() != 0) sb.errors++;
    $display("Covered %0d input words: %0d schedule writes, %0d evaluations, %0d setups",
             sb.writes + sb.evals, sb.writes, sb.evals, config_phases);
    $display("Checked %0d result words: %0d drive-on, %0d drive-off, %0d status",
             sb.words_checked, sb.on_words, sb.off_words, sb.status_words);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
